@@ design/cpc_pkg.sv @@
// shared widths, payload types and helpers for the circle pair collision pipeline
package cpc_pkg;

  localparam int COORD_W = 20;
  localparam int RAD_W   = 19;
  localparam int ABS_W   = 20;
  localparam int SQR_W   = 40;
  localparam int D2_W    = 41;
  localparam int RES_W   = 42;
  localparam int ROOT_W  = 21;
  localparam int OVL_W   = 21;
  localparam int NUM_W   = 43;
  localparam int Q_W     = 21;
  localparam int DVS_W   = 22;
  localparam int SQ_STEPS  = 21;
  localparam int DIV_STEPS = 21;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 20'sh7FFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = -20'sh80000;

  typedef struct packed {
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [COORD_W-1:0] tx;
    logic signed [COORD_W-1:0] ty;
    logic [ABS_W-1:0]          adx;
    logic [ABS_W-1:0]          ady;
    logic                      sgnx;
    logic                      sgny;
    logic [COORD_W-1:0]        rsum;
    logic                      coinc;
    logic                      overlap;
    logic                      push;
  } pl_t;

  typedef struct packed {
    logic [D2_W-1:0]  n;
    logic [RES_W-1:0] res;
    pl_t              pl;
  } sq_t;

  typedef struct packed {
    logic [NUM_W-1:0] remx;
    logic [NUM_W-1:0] remy;
    logic [Q_W-1:0]   qx;
    logic [Q_W-1:0]   qy;
    logic [DVS_W-1:0] dvs;
    pl_t              pl;
  } dv_t;

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [COORD_W+2:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > (COORD_W+3)'(COORD_MAX)) begin
      r = COORD_MAX;
    end else if (v < (COORD_W+3)'(COORD_MIN)) begin
      r = COORD_MIN;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ design/cpc_if.sv @@
// stream channel interfaces for circle pairs and resolved centres
interface cpc_in_if;
  logic               valid;
  logic               ready;
  logic signed [19:0] src_x;
  logic signed [19:0] src_y;
  logic [18:0]        src_radius;
  logic signed [19:0] dst_x;
  logic signed [19:0] dst_y;
  logic [18:0]        dst_radius;
  modport source (output valid, src_x, src_y, src_radius, dst_x, dst_y, dst_radius,
                  input ready);
  modport sink (input valid, src_x, src_y, src_radius, dst_x, dst_y, dst_radius,
                output ready);
endinterface

interface cpc_out_if;
  logic               valid;
  logic               ready;
  logic               overlapping;
  logic               coincident;
  logic signed [19:0] new_src_x;
  logic signed [19:0] new_src_y;
  logic signed [19:0] new_dst_x;
  logic signed [19:0] new_dst_y;
  modport source (output valid, overlapping, coincident, new_src_x, new_src_y,
                  new_dst_x, new_dst_y, input ready);
  modport sink (input valid, overlapping, coincident, new_src_x, new_src_y,
                new_dst_x, new_dst_y, output ready);
endinterface

@@ design/cpc_sqrt_cell.sv @@
// one root bit of the digit-by-digit integer square root
module cpc_sqrt_cell
  import cpc_pkg::*;
#(
  parameter int LEVEL = 0
) (
  input  logic clk,
  input  logic en,
  input  sq_t  d_i,
  output sq_t  d_o
);

  localparam logic [RES_W-1:0] BITV = RES_W'(1) << (2 * LEVEL);

  sq_t             q_r;
  sq_t             q_nxt;
  logic [RES_W:0]  trial;

  always_comb begin
    trial = {1'b0, d_i.res} + {1'b0, BITV};
    q_nxt = d_i;
    if ({2'b00, d_i.n} >= trial) begin
      q_nxt.n   = d_i.n - trial[D2_W-1:0];
      q_nxt.res = (d_i.res >> 1) + BITV;
    end else begin
      q_nxt.res = d_i.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign d_o = q_r;

endmodule

@@ design/cpc_div_cell.sv @@
// one quotient bit of the restoring divider, both axes side by side
module cpc_div_cell
  import cpc_pkg::*;
#(
  parameter int SHIFT = 0
) (
  input  logic clk,
  input  logic en,
  input  dv_t  d_i,
  output dv_t  d_o
);

  dv_t              q_r;
  dv_t              q_nxt;
  logic [NUM_W-1:0] ds;

  always_comb begin
    ds    = NUM_W'(d_i.dvs) << SHIFT;
    q_nxt = d_i;
    if (d_i.remx >= ds) begin
      q_nxt.remx      = d_i.remx - ds;
      q_nxt.qx[SHIFT] = 1'b1;
    end
    if (d_i.remy >= ds) begin
      q_nxt.remy      = d_i.remy - ds;
      q_nxt.qy[SHIFT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign d_o = q_r;

endmodule

@@ design/circle_pair_collision_resolve.sv @@
// circle pair overlap test and push-apart, pipelined root and divider cells
//
//  channel   dir  transfer when          payload
//  in_chan   in   valid && ready         src/dst centres and radii
//  out_chan  out  valid && ready         overlap flags, resolved centres
//
// one pair per cycle sustained while out_chan is ready
// the pipeline is 21 square-root cells and 21 divider cells plus 5 stages
// each stage holds its item only while the next one is full and stalled
// reset clears all stage valid bits; data registers are not reset
module circle_pair_collision_resolve
  import cpc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  cpc_in_if.sink    in_chan,
  cpc_out_if.source out_chan
);

  localparam int ST_P0  = 0;
  localparam int ST_P1  = 1;
  localparam int ST_P2  = 2;
  localparam int ST_SQ0 = 3;
  localparam int ST_M   = ST_SQ0 + SQ_STEPS;
  localparam int ST_DV0 = ST_M + 1;
  localparam int ST_OUT = ST_DV0 + DIV_STEPS;
  localparam int NST    = ST_OUT + 1;

  logic [NST-1:0] v_r;
  logic [NST-1:0] rdy;

  always_comb begin
    rdy[NST-1] = !v_r[NST-1] || out_chan.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (rdy[k]) begin
          v_r[k] <= (k == 0) ? in_chan.valid : v_r[k-1];
        end
      end
    end
  end

  assign in_chan.ready = rdy[ST_P0];

  // stage p0: differences and radius sum
  pl_t                     p0_r;
  pl_t                     p0_nxt;
  logic signed [COORD_W:0] dx;
  logic signed [COORD_W:0] dy;

  always_comb begin
    dx = $signed({in_chan.src_x[COORD_W-1], in_chan.src_x})
         - $signed({in_chan.dst_x[COORD_W-1], in_chan.dst_x});
    dy = $signed({in_chan.src_y[COORD_W-1], in_chan.src_y})
         - $signed({in_chan.dst_y[COORD_W-1], in_chan.dst_y});
    p0_nxt         = '0;
    p0_nxt.sx      = in_chan.src_x;
    p0_nxt.sy      = in_chan.src_y;
    p0_nxt.tx      = in_chan.dst_x;
    p0_nxt.ty      = in_chan.dst_y;
    p0_nxt.sgnx    = dx[COORD_W];
    p0_nxt.sgny    = dy[COORD_W];
    p0_nxt.adx     = dx[COORD_W] ? ABS_W'(-dx) : ABS_W'(dx);
    p0_nxt.ady     = dy[COORD_W] ? ABS_W'(-dy) : ABS_W'(dy);
    p0_nxt.rsum    = COORD_W'(in_chan.src_radius) + COORD_W'(in_chan.dst_radius);
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_P0]) begin
      p0_r <= p0_nxt;
    end
  end

  // stage p1: squares
  pl_t              p1_r;
  logic [SQR_W-1:0] sqx_r;
  logic [SQR_W-1:0] sqy_r;

  always_ff @(posedge clk) begin
    if (rdy[ST_P1]) begin
      p1_r  <= p0_r;
      sqx_r <= p0_r.adx * p0_r.adx;
      sqy_r <= p0_r.ady * p0_r.ady;
    end
  end

  // stage p2: squared distance
  sq_t             p2_r;
  sq_t             p2_nxt;
  logic [D2_W-1:0] d2;

  always_comb begin
    d2             = D2_W'(sqx_r) + D2_W'(sqy_r);
    p2_nxt.n       = d2;
    p2_nxt.res     = '0;
    p2_nxt.pl      = p1_r;
    p2_nxt.pl.coinc = (d2 == '0);
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_P2]) begin
      p2_r <= p2_nxt;
    end
  end

  // square-root cells
  sq_t sq_w [SQ_STEPS+1];
  assign sq_w[0] = p2_r;

  for (genvar c = 0; c < SQ_STEPS; c++) begin : g_sq
    cpc_sqrt_cell #(.LEVEL(SQ_STEPS - 1 - c)) u_cell (
      .clk (clk),
      .en  (rdy[ST_SQ0 + c]),
      .d_i (sq_w[c]),
      .d_o (sq_w[c+1])
    );
  end

  // stage m: overlap test and numerators
  dv_t                     m_r;
  dv_t                     m_nxt;
  logic [ROOT_W-1:0]       root_d;
  logic [OVL_W-1:0]        ovl;
  logic [OVL_W+ABS_W-1:0]  prx;
  logic [OVL_W+ABS_W-1:0]  pry;
  logic                    ov;
  logic                    psh;

  always_comb begin
    root_d      = sq_w[SQ_STEPS].res[ROOT_W-1:0];
    ov          = OVL_W'(sq_w[SQ_STEPS].pl.rsum) >= root_d;
    psh         = ov && (root_d != '0);
    ovl         = OVL_W'(sq_w[SQ_STEPS].pl.rsum) - root_d;
    prx         = ovl * sq_w[SQ_STEPS].pl.adx;
    pry         = ovl * sq_w[SQ_STEPS].pl.ady;
    m_nxt.pl    = sq_w[SQ_STEPS].pl;
    m_nxt.pl.overlap = ov;
    m_nxt.pl.push    = psh;
    m_nxt.qx    = '0;
    m_nxt.qy    = '0;
    m_nxt.dvs   = {root_d, 1'b0};
    m_nxt.remx  = psh ? NUM_W'(prx) + NUM_W'(root_d) : '0;
    m_nxt.remy  = psh ? NUM_W'(pry) + NUM_W'(root_d) : '0;
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_M]) begin
      m_r <= m_nxt;
    end
  end

  // divider cells
  dv_t dv_w [DIV_STEPS+1];
  assign dv_w[0] = m_r;

  for (genvar c = 0; c < DIV_STEPS; c++) begin : g_dv
    cpc_div_cell #(.SHIFT(DIV_STEPS - 1 - c)) u_cell (
      .clk (clk),
      .en  (rdy[ST_DV0 + c]),
      .d_i (dv_w[c]),
      .d_o (dv_w[c+1])
    );
  end

  // output stage: apply moves and saturate
  dv_t                       fin;
  logic signed [COORD_W+2:0] mx;
  logic signed [COORD_W+2:0] my;
  logic signed [COORD_W-1:0] nsx_nxt;
  logic signed [COORD_W-1:0] nsy_nxt;
  logic signed [COORD_W-1:0] ntx_nxt;
  logic signed [COORD_W-1:0] nty_nxt;
  logic signed [COORD_W-1:0] nsx_r;
  logic signed [COORD_W-1:0] nsy_r;
  logic signed [COORD_W-1:0] ntx_r;
  logic signed [COORD_W-1:0] nty_r;
  logic                      ovl_r;
  logic                      coinc_r;

  always_comb begin
    fin = dv_w[DIV_STEPS];
    mx  = $signed({2'b00, fin.qx});
    my  = $signed({2'b00, fin.qy});
    if (fin.pl.sgnx) begin
      mx = -mx;
    end
    if (fin.pl.sgny) begin
      my = -my;
    end
    if (fin.pl.push) begin
      nsx_nxt = sat_coord((COORD_W+3)'(fin.pl.sx) + mx);
      nsy_nxt = sat_coord((COORD_W+3)'(fin.pl.sy) + my);
      ntx_nxt = sat_coord((COORD_W+3)'(fin.pl.tx) - mx);
      nty_nxt = sat_coord((COORD_W+3)'(fin.pl.ty) - my);
    end else begin
      nsx_nxt = fin.pl.sx;
      nsy_nxt = fin.pl.sy;
      ntx_nxt = fin.pl.tx;
      nty_nxt = fin.pl.ty;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_OUT]) begin
      nsx_r   <= nsx_nxt;
      nsy_r   <= nsy_nxt;
      ntx_r   <= ntx_nxt;
      nty_r   <= nty_nxt;
      ovl_r   <= fin.pl.overlap;
      coinc_r <= fin.pl.coinc;
    end
  end

  assign out_chan.valid       = v_r[ST_OUT];
  assign out_chan.overlapping = ovl_r;
  assign out_chan.coincident  = coinc_r;
  assign out_chan.new_src_x   = nsx_r;
  assign out_chan.new_src_y   = nsy_r;
  assign out_chan.new_dst_x   = ntx_r;
  assign out_chan.new_dst_y   = nty_r;

  a_coinc_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.coincident |-> out_chan.overlapping)
    else $error("coincident result without overlap");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> v_r[ST_P0] && v_r[ST_OUT])
    else $error("input stalled with a free stage");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_chan.valid)
    else $error("result valid right after reset");

  a_push_quotient: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ST_OUT - 1] && fin.pl.push |-> !fin.qx[Q_W-1] && !fin.qy[Q_W-1])
    else $error("move exceeds half the overlap range");

endmodule
